[rtl/legv8_subset_execute_unit_macros.svh]
// assertion macros used by the execute unit back end
`ifndef LEGV8_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define LEGV8_SUBSET_EXECUTE_UNIT_MACROS_SVH

// condition and consequence in the same cycle
`define LSX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define LSX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lsx_pkg.sv]
// types, codes and constants of the legv8 subset execute unit
package lsx_pkg;

    localparam int DATA_WORDS = 256;
    localparam int REG_COUNT  = 32;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);
    localparam int QDEPTH     = 2;
    localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW        = $clog2(QDEPTH + 1);

    localparam logic [4:0] SP_IDX   = 5'd28;
    localparam logic [4:0] LINK_IDX = 5'd30;

    localparam logic [31:0] PC_START_RST    = 32'd200;
    localparam logic [31:0] MEM_BASE_RST    = 32'd100;
    localparam logic [31:0] STACK_INIT_RST  = 32'd900;
    localparam logic [31:0] STACK_LIMIT_RST = 32'd400;
    localparam logic [31:0] WORD_BYTES      = 32'd4;

    // operation codes
    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_ADDI    = 4'd2;
    localparam logic [3:0] OP_SUBI    = 4'd3;
    localparam logic [3:0] OP_LDUR    = 4'd4;
    localparam logic [3:0] OP_STUR    = 4'd5;
    localparam logic [3:0] OP_B       = 4'd6;
    localparam logic [3:0] OP_BL      = 4'd7;
    localparam logic [3:0] OP_BR      = 4'd8;
    localparam logic [3:0] OP_CBZ     = 4'd9;
    localparam logic [3:0] OP_PRELOAD = 4'd10;
    localparam logic [3:0] OP_HALT    = 4'd11;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HALTED   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_MISS     = 3'd3;
    localparam logic [2:0] ST_STOPPED  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_PC_START    = 2'd0;
    localparam logic [1:0] CFG_MEM_BASE    = 2'd1;
    localparam logic [1:0] CFG_STACK_INIT  = 2'd2;
    localparam logic [1:0] CFG_STACK_LIMIT = 2'd3;

    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         reg_dest;
        logic [4:0]         reg_a;
        logic [4:0]         reg_b;
        logic signed [31:0] immediate;
        logic signed [31:0] preload_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        next_pc;
        logic               reg_written;
        logic [4:0]         written_index;
        logic signed [31:0] written_value;
    } out_item_t;

    // classified instruction held in the queue between front and back
    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         reg_dest;
        logic [4:0]         reg_a;
        logic [4:0]         port_b;
        logic [31:0]        imm;
        logic [31:0]        imm_x4;
        logic [31:0]        imm_off;
        logic [31:0]        pval;
        logic               pre_hit;
        logic [DMEM_AW-1:0] pre_idx;
    } dec_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_wr_t;

endpackage

[rtl/lsx_front.sv]
// front end: accepts requests, classifies them and queues them for the back end
module lsx_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lsx_pkg::in_item_t in_item,
    input  logic [31:0]      mem_base,
    output logic             q_valid,
    output lsx_pkg::dec_t    q_item,
    input  logic             q_pop
);
    import lsx_pkg::*;

    dec_t           dec;
    logic [31:0]    pre_off;
    logic           push;
    dec_t           q_mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    // classify the request and precompute address offsets
    always_comb
    begin
        pre_off      = in_item.immediate - mem_base;
        dec.op       = in_item.op;
        dec.reg_dest = in_item.reg_dest;
        dec.reg_a    = in_item.reg_a;
        dec.port_b   = (in_item.op == OP_STUR) ? in_item.reg_dest : in_item.reg_b;
        dec.imm      = in_item.immediate;
        dec.imm_x4   = {in_item.immediate[29:0], 2'b00};
        dec.imm_off  = in_item.immediate - mem_base;
        dec.pval     = in_item.preload_value;
        dec.pre_hit  = (pre_off[1:0] == 2'b00) && (pre_off[31:2] < 30'(DATA_WORDS));
        dec.pre_idx  = pre_off[DMEM_AW+1:2];
    end

    assign in_stall = (count_reg == QCW'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[rtl/lsx_back.sv]
// back end: register file, data memory, program counter and result register
`include "legv8_subset_execute_unit_macros.svh"

module lsx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  lsx_pkg::dec_t     q_item,
    output logic              q_pop,
    input  lsx_pkg::cfg_wr_t  cfg_wr,
    input  logic [31:0]       stack_limit,
    output logic              out_valid,
    input  logic              out_stall,
    output lsx_pkg::out_item_t out_item
);
    import lsx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]         st_reg, st_next;
    dec_t               ex_reg;
    logic [31:0]        rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [31:0]        ra_data_reg, rb_data_reg;
    logic               ra_vld_reg, rb_vld_reg;
    logic [31:0]        dm_mem [DATA_WORDS];
    logic [31:0]        dm_rdata_reg;
    logic [31:0]        pc_reg;
    logic [31:0]        sp_reg;
    logic               stopped_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               out_free, exec_fire, load_fire, done;
    logic [31:0]        a_val, b_val, pc_inc, ls_off;
    logic               ls_hit;
    logic [DMEM_AW-1:0] ls_idx;
    logic [2:0]         ex_status;
    logic               ex_wr, ex_stop, ex_to_load, ex_dm_we, ex_pc_we;
    logic [4:0]         ex_widx;
    logic [31:0]        ex_wval, ex_pc;
    logic [DMEM_AW-1:0] ex_dm_idx;
    logic [31:0]        ex_dm_wdata;
    logic               rf_we;
    logic [4:0]         rf_waddr;
    logic [31:0]        rf_wdata;
    out_item_t          res;

    // operands: the stack pointer lives in its own register
    always_comb
    begin
        a_val  = (ex_reg.reg_a == SP_IDX) ? sp_reg : (ra_vld_reg ? ra_data_reg : '0);
        b_val  = (ex_reg.port_b == SP_IDX) ? sp_reg : (rb_vld_reg ? rb_data_reg : '0);
        pc_inc = pc_reg + WORD_BYTES;
        ls_off = a_val + ex_reg.imm_off;
        ls_hit = (ls_off[1:0] == 2'b00) && (ls_off[31:2] < 30'(DATA_WORDS));
        ls_idx = ls_off[DMEM_AW+1:2];
    end

    // execute one instruction
    always_comb
    begin
        ex_status   = ST_OK;
        ex_wr       = 1'b0;
        ex_widx     = '0;
        ex_wval     = '0;
        ex_pc       = pc_reg;
        ex_pc_we    = 1'b0;
        ex_stop     = 1'b0;
        ex_to_load  = 1'b0;
        ex_dm_we    = 1'b0;
        ex_dm_idx   = ls_idx;
        ex_dm_wdata = b_val;
        if (stopped_reg)
        begin
            ex_status = ST_STOPPED;
        end
        else if (ex_reg.op == OP_PRELOAD)
        begin
            ex_dm_idx   = ex_reg.pre_idx;
            ex_dm_wdata = ex_reg.pval;
            ex_dm_we    = ex_reg.pre_hit;
            ex_status   = ex_reg.pre_hit ? ST_OK : ST_MISS;
        end
        else if ($signed(sp_reg) <= $signed(stack_limit))
        begin
            ex_status = ST_OVERFLOW;
            ex_stop   = 1'b1;
        end
        else
        begin
            ex_pc_we = 1'b1;
            ex_pc    = pc_inc;
            case (ex_reg.op)
                OP_ADD:
                begin
                    ex_wr   = 1'b1;
                    ex_widx = ex_reg.reg_dest;
                    ex_wval = a_val + b_val;
                end
                OP_SUB:
                begin
                    ex_wr   = 1'b1;
                    ex_widx = ex_reg.reg_dest;
                    ex_wval = a_val - b_val;
                end
                OP_ADDI:
                begin
                    ex_wr   = 1'b1;
                    ex_widx = ex_reg.reg_dest;
                    ex_wval = a_val + ex_reg.imm;
                end
                OP_SUBI:
                begin
                    ex_wr   = 1'b1;
                    ex_widx = ex_reg.reg_dest;
                    ex_wval = a_val - ex_reg.imm;
                end
                OP_LDUR:
                begin
                    ex_to_load = ls_hit;
                    ex_status  = ls_hit ? ST_OK : ST_MISS;
                end
                OP_STUR:
                begin
                    ex_dm_we  = ls_hit;
                    ex_status = ls_hit ? ST_OK : ST_MISS;
                end
                OP_B:
                begin
                    ex_pc = pc_reg + ex_reg.imm_x4;
                end
                OP_BL:
                begin
                    ex_wr   = 1'b1;
                    ex_widx = LINK_IDX;
                    ex_wval = pc_inc;
                    ex_pc   = pc_reg + ex_reg.imm_x4;
                end
                OP_BR:
                begin
                    ex_pc = a_val;
                end
                OP_CBZ:
                begin
                    ex_pc = (a_val == '0) ? pc_reg + ex_reg.imm_x4 : pc_inc;
                end
                OP_HALT:
                begin
                    ex_pc     = pc_reg;
                    ex_status = ST_HALTED;
                    ex_stop   = 1'b1;
                end
                default:
                begin
                    ex_pc = pc_inc;
                end
            endcase
        end
    end

    // sequencing and queue pop
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        exec_fire = (st_reg == S_EXEC) && out_free;
        load_fire = (st_reg == S_LOAD) && out_free;
        done      = (exec_fire && !ex_to_load) || load_fire;
        q_pop     = q_valid && ((st_reg == S_IDLE) || done);
        st_next   = st_reg;
        if (q_pop)
        begin
            st_next = S_EXEC;
        end
        else if (exec_fire && ex_to_load)
        begin
            st_next = S_LOAD;
        end
        else if (done)
        begin
            st_next = S_IDLE;
        end
    end

    // register file write port and result
    always_comb
    begin
        rf_we    = load_fire || (exec_fire && ex_wr);
        rf_waddr = load_fire ? ex_reg.reg_dest : ex_widx;
        rf_wdata = load_fire ? dm_rdata_reg : ex_wval;
        if (load_fire)
        begin
            res.status        = ST_OK;
            res.next_pc       = pc_reg;
            res.reg_written   = 1'b1;
            res.written_index = ex_reg.reg_dest;
            res.written_value = dm_rdata_reg;
        end
        else
        begin
            res.status        = ex_status;
            res.next_pc       = ex_pc;
            res.reg_written   = ex_wr;
            res.written_index = ex_widx;
            res.written_value = ex_wval;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            pc_reg        <= PC_START_RST;
            sp_reg        <= STACK_INIT_RST;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_vld_reg    <= '0;
            ra_vld_reg    <= 1'b0;
            rb_vld_reg    <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_wr.we && (cfg_wr.index == CFG_PC_START))
            begin
                pc_reg <= cfg_wr.data;
            end
            else if (exec_fire && ex_pc_we)
            begin
                pc_reg <= ex_pc;
            end
            if (cfg_wr.we && (cfg_wr.index == CFG_STACK_INIT))
            begin
                sp_reg <= cfg_wr.data;
            end
            else if (rf_we && (rf_waddr == SP_IDX))
            begin
                sp_reg <= rf_wdata;
            end
            if (exec_fire && ex_stop)
            begin
                stopped_reg <= 1'b1;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (rf_we)
            begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            // operand valid flags, with bypass of a write at the same edge
            if (q_pop)
            begin
                ra_vld_reg <= rf_vld_reg[q_item.reg_a] ||
                              (rf_we && (rf_waddr == q_item.reg_a));
                rb_vld_reg <= rf_vld_reg[q_item.port_b] ||
                              (rf_we && (rf_waddr == q_item.port_b));
            end
        end
    end

    // register file memory with registered read data
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (q_pop)
        begin
            ex_reg      <= q_item;
            ra_data_reg <= (rf_we && (rf_waddr == q_item.reg_a)) ? rf_wdata
                                                                  : rf_mem[q_item.reg_a];
            rb_data_reg <= (rf_we && (rf_waddr == q_item.port_b)) ? rf_wdata
                                                                   : rf_mem[q_item.port_b];
        end
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (exec_fire && ex_dm_we)
        begin
            dm_mem[ex_dm_idx] <= ex_dm_wdata;
        end
        if (exec_fire && ex_to_load)
        begin
            dm_rdata_reg <= dm_mem[ls_idx];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `LSX_ASSERT_NEXT(a_stopped_reports, clk, rst_n, exec_fire && stopped_reg, out_valid_reg && (out_item_reg.status == ST_STOPPED), "stopped unit did not report stopped status")
    `LSX_ASSERT_NOW(a_load_follows_exec, clk, rst_n, st_reg == S_LOAD, ($past(st_reg) == S_EXEC) || ($past(st_reg) == S_LOAD), "load state entered without execute")
    `LSX_ASSERT_NOW(a_no_write_zero, clk, rst_n, out_valid_reg && !out_item_reg.reg_written, (out_item_reg.written_index == '0) && (out_item_reg.written_value == '0), "unwritten result carries nonzero index or value")
    `LSX_ASSERT_NEXT(a_stop_sticks, clk, rst_n, stopped_reg, stopped_reg, "stopped flag cleared without reset")

endmodule

[rtl/legv8_subset_execute_unit.sv]
// Executes one decoded LEGv8 subset instruction per request and returns one result per request.
// A request waits in the 2-entry queue; the register file is read as it is popped into the
// execute register, then executed, writing the register file and the result register.
// A load that hits data memory also passes through the registered data memory read.
// Back to back the back end retires one request per cycle, a load hit only after its read;
// a stalled output holds it while the queue goes on taking requests until full. Configuration
// writes are taken at any time and must only be issued while the unit is idle.
module legv8_subset_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lsx_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output lsx_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import lsx_pkg::*;

    logic [31:0] mem_base_reg;
    logic [31:0] stack_limit_reg;
    cfg_wr_t     cfg_wr;
    logic        q_valid;
    dec_t        q_item;
    logic        q_pop;

    // configuration port
    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_base_reg    <= MEM_BASE_RST;
            stack_limit_reg <= STACK_LIMIT_RST;
        end
        else if (cfg_wr.we)
        begin
            case (cfg_wr.index)
                CFG_MEM_BASE:    mem_base_reg    <= cfg_wr.data;
                CFG_STACK_LIMIT: stack_limit_reg <= cfg_wr.data;
                default:         ;
            endcase
        end
    end

    // classify and queue
    lsx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .mem_base (mem_base_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // execute
    lsx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .cfg_wr      (cfg_wr),
        .stack_limit (stack_limit_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

[test/legv8_subset_execute_unit_checker.sv]
// checker for the legv8 subset execute unit: predicts every result and compares it
module legv8_subset_execute_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  lsx_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  lsx_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 mismatch_count,
    output int                 pending
);
    import lsx_pkg::*;

    // architectural copy of the unit
    logic [31:0] arch_regs [REG_COUNT];
    logic [31:0] arch_mem [DATA_WORDS];
    logic [31:0] arch_pc;
    logic        arch_stopped;
    logic [31:0] mem_base_q;
    logic [31:0] stack_limit_q;

    // results owed by the unit, oldest first
    out_item_t expected_results [$];

    // byte address to data word, miss when unaligned or past the end
    function automatic logic map_word(input logic [31:0] addr, output logic [DMEM_AW-1:0] idx);
        logic [31:0] off;
        off = addr - mem_base_q;
        idx = off[DMEM_AW+1:2];
        return (off[1:0] == 2'b00) && (off[31:2] < 30'(DATA_WORDS));
    endfunction

    // runs one request on the architectural copy and returns its result
    function automatic out_item_t execute_instr(input in_item_t req);
        out_item_t res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] imm_x4;
        logic [31:0] npc;
        logic [DMEM_AW-1:0] widx;
        res = '0;
        res.status = ST_OK;
        imm = req.immediate;
        imm_x4 = {imm[29:0], 2'b00};
        npc = arch_pc;
        a = arch_regs[req.reg_a];
        b = arch_regs[req.reg_b];
        if (arch_stopped)
            res.status = ST_STOPPED;
        else if (req.op == OP_PRELOAD)
        begin
            // preload skips the stack check and leaves the pc alone
            if (map_word(imm, widx))
                arch_mem[widx] = req.preload_value;
            else
                res.status = ST_MISS;
        end
        else if ($signed(arch_regs[SP_IDX]) <= $signed(stack_limit_q))
        begin
            res.status = ST_OVERFLOW;
            arch_stopped = 1'b1;
        end
        else
        begin
            case (req.op)
                OP_ADD, OP_SUB, OP_ADDI, OP_SUBI:
                begin
                    res.reg_written = 1'b1;
                    res.written_index = req.reg_dest;
                    case (req.op)
                        OP_ADD:  res.written_value = a + b;
                        OP_SUB:  res.written_value = a - b;
                        OP_ADDI: res.written_value = a + imm;
                        default: res.written_value = a - imm;
                    endcase
                    npc = npc + WORD_BYTES;
                end
                OP_LDUR:
                begin
                    if (map_word(a + imm, widx))
                    begin
                        res.reg_written = 1'b1;
                        res.written_index = req.reg_dest;
                        res.written_value = arch_mem[widx];
                    end
                    else
                        res.status = ST_MISS;
                    npc = npc + WORD_BYTES;
                end
                OP_STUR:
                begin
                    if (map_word(a + imm, widx))
                        arch_mem[widx] = arch_regs[req.reg_dest];
                    else
                        res.status = ST_MISS;
                    npc = npc + WORD_BYTES;
                end
                OP_B:
                    npc = npc + imm_x4;
                OP_BL:
                begin
                    res.reg_written = 1'b1;
                    res.written_index = LINK_IDX;
                    res.written_value = npc + WORD_BYTES;
                    npc = npc + imm_x4;
                end
                OP_BR:
                    npc = a;
                OP_CBZ:
                    npc = npc + ((a == 32'd0) ? imm_x4 : WORD_BYTES);
                OP_HALT:
                begin
                    res.status = ST_HALTED;
                    arch_stopped = 1'b1;
                end
                default:
                    npc = npc + WORD_BYTES;
            endcase
            if (res.reg_written)
                arch_regs[res.written_index] = res.written_value;
            arch_pc = npc;
        end
        res.next_pc = arch_pc;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        if (!rst_n)
        begin
            mem_base_q = MEM_BASE_RST;
            stack_limit_q = STACK_LIMIT_RST;
            for (int i = 0; i < REG_COUNT; i++)
                arch_regs[i] = '0;
            arch_regs[SP_IDX] = STACK_INIT_RST;
            arch_pc = PC_START_RST;
            arch_stopped = 1'b0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // compare an accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting: %0h", out_item);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, out_item.status);
                    check_field("next_pc", want.next_pc, out_item.next_pc);
                    check_field("reg_written", want.reg_written, out_item.reg_written);
                    check_field("written_index", want.written_index, out_item.written_index);
                    check_field("written_value", want.written_value, out_item.written_value);
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PC_START:
                        arch_pc = cfg_data;
                    CFG_MEM_BASE:
                        mem_base_q = cfg_data;
                    CFG_STACK_INIT:
                        arch_regs[SP_IDX] = cfg_data;
                    CFG_STACK_LIMIT:
                        stack_limit_q = cfg_data;
                    default:
                        ;
                endcase
            end

            // predict each accepted request
            if (in_valid && !in_stall)
                expected_results.push_back(execute_instr(in_item));

            pending <= expected_results.size();
        end
    end

endmodule

[test/legv8_subset_execute_unit_tb.sv]
// top of the execute unit testbench: clock, reset, stimulus and verdict
module legv8_subset_execute_unit_tb;
    import lsx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 200;
    localparam logic [31:0] MIN_WORD = 32'h8000_0000;
    localparam logic [31:0] MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [3:0] OP_SPARE_FIRST = 4'd12;
    localparam logic [3:0] OP_SPARE_LAST = 4'd15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PC_START;
    logic [31:0] cfg_data = '0;
    int          mismatch_count;
    int          pending;

    int          cycle_count = 0;
    int          sent_count = 0;
    int          long_hold = 0;
    bit          idle_on = 1'b0;
    logic [31:0] cur_mem_base = MEM_BASE_RST;

    legv8_subset_execute_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    legv8_subset_execute_unit_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                hold = long_hold;
                long_hold = 0;
            end
            else
                hold = idle_on ? $urandom_range(0, 5) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic in_item_t make_req(input logic [3:0] op, input logic [4:0] rd,
                                          input logic [4:0] ra, input logic [4:0] rb,
                                          input logic [31:0] imm, input logic [31:0] pval);
        in_item_t req;
        req.op = op;
        req.reg_dest = rd;
        req.reg_a = ra;
        req.reg_b = rb;
        req.immediate = imm;
        req.preload_value = pval;
        return req;
    endfunction

    // data word weighted toward the edges of the range
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return MAX_WORD;
            1: return MIN_WORD;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return 32'($urandom_range(0, 16));
            5: return 32'd0 - 32'($urandom_range(1, 16));
            default: return $urandom();
        endcase
    endfunction

    // any value the stack pointer may hold without tripping the lowest limit
    function automatic logic [31:0] safe_word();
        logic [31:0] v;
        v = rand_word();
        return (v == MIN_WORD) ? MAX_WORD : v;
    endfunction

    function automatic logic [4:0] rand_reg();
        return 5'($urandom_range(0, REG_COUNT - 1));
    endfunction

    // destination that is never the stack pointer
    function automatic logic [4:0] rand_target();
        logic [4:0] r;
        r = 5'($urandom_range(0, REG_COUNT - 2));
        return (r >= SP_IDX) ? r + 5'd1 : r;
    endfunction

    // byte offset from the memory base that lands on a word
    function automatic logic [31:0] hit_offset();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'(DATA_WORDS - 1) << 2;
            default: return 32'($urandom_range(0, DATA_WORDS - 1)) << 2;
        endcase
    endfunction

    // byte offset that is unaligned, past the top or below the base
    function automatic logic [31:0] miss_offset();
        case ($urandom_range(0, 2))
            0: return hit_offset() + 32'($urandom_range(1, 3));
            1: return 32'(DATA_WORDS + $urandom_range(0, 1000)) << 2;
            default: return 32'd0 - (32'($urandom_range(1, 1000)) << 2);
        endcase
    endfunction

    // offer one request and hold it until taken
    task automatic send_req(input in_item_t req);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // new settings, written only once the unit has drained
    task automatic configure(input logic [31:0] pc0, input logic [31:0] base,
                             input logic [31:0] sp0, input logic [31:0] sp_lim);
        wait_idle();
        cfg_write(CFG_PC_START, pc0);
        cfg_write(CFG_MEM_BASE, base);
        cfg_write(CFG_STACK_INIT, sp0);
        cfg_write(CFG_STACK_LIMIT, sp_lim);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_mem_base = base;
    endtask

    // stack pointer is zeroed first so the final value is known to stay above the limit
    task automatic stack_write();
        logic [4:0] src;
        src = rand_reg();
        send_req(make_req(OP_SUB, SP_IDX, src, src, rand_word(), rand_word()));
        send_req(make_req(($urandom_range(0, 1) == 1) ? OP_ADDI : OP_SUBI, SP_IDX, SP_IDX,
                          rand_reg(), safe_word(), rand_word()));
    endtask

    // zero a base register, maybe add an offset, then loads, stores and preloads around it
    task automatic memory_sequence();
        logic [4:0] base_reg;
        logic [4:0] src;
        logic [31:0] base_val;
        logic [31:0] offset;
        base_reg = rand_target();
        src = rand_reg();
        base_val = ($urandom_range(0, 1) == 1) ? rand_word() : 32'd0;
        send_req(make_req(OP_SUB, base_reg, src, src, rand_word(), rand_word()));
        if (base_val != 32'd0)
            send_req(make_req(OP_ADDI, base_reg, base_reg, rand_reg(), base_val, rand_word()));
        repeat ($urandom_range(1, 5))
        begin
            offset = ($urandom_range(0, 7) == 0) ? miss_offset() : hit_offset();
            case ($urandom_range(0, 2))
                0: send_req(make_req(OP_STUR, rand_reg(), base_reg, rand_reg(),
                                     cur_mem_base + offset - base_val, rand_word()));
                1: send_req(make_req(OP_LDUR, rand_target(), base_reg, rand_reg(),
                                     cur_mem_base + offset - base_val, rand_word()));
                default: send_req(make_req(OP_PRELOAD, rand_reg(), rand_reg(), rand_reg(),
                                           cur_mem_base + offset, rand_word()));
            endcase
        end
    endtask

    // zero a register, then a conditional or register branch on it, or random conditional branches and links
    task automatic branch_sequence();
        logic [4:0] z;
        logic [4:0] src;
        z = rand_target();
        src = rand_reg();
        send_req(make_req(OP_SUB, z, src, src, rand_word(), rand_word()));
        case ($urandom_range(0, 2))
            0: send_req(make_req(OP_CBZ, rand_reg(), z, rand_reg(), rand_word(), rand_word()));
            1:
            begin
                send_req(make_req(OP_ADDI, z, z, rand_reg(), rand_word(), rand_word()));
                send_req(make_req(OP_BR, rand_reg(), z, rand_reg(), rand_word(), rand_word()));
            end
            default:
            begin
                send_req(make_req(OP_CBZ, rand_reg(), rand_reg(), rand_reg(), rand_word(),
                                  rand_word()));
                send_req(make_req(OP_BL, rand_reg(), rand_reg(), rand_reg(), rand_word(),
                                  rand_word()));
            end
        endcase
    endtask

    // any operation but halt, fields at random
    task automatic single_op();
        logic [3:0] op;
        logic [4:0] rd;
        op = 4'($urandom_range(0, 14));
        if (op >= OP_HALT)
            op = op + 4'd1;
        rd = rand_reg();
        // codes up to the load write their destination
        if (rd == SP_IDX && op <= OP_LDUR)
            stack_write();
        else
            send_req(make_req(op, rd, rand_reg(), rand_reg(), rand_word(), rand_word()));
    endtask

    task automatic random_items(input int count);
        int goal;
        goal = sent_count + count;
        while (sent_count < goal)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: memory_sequence();
                4, 5, 6: single_op();
                7: branch_sequence();
                8: stack_write();
                default: send_req(make_req(OP_PRELOAD, rand_reg(), rand_reg(), rand_reg(),
                                           ($urandom_range(0, 3) == 0) ? rand_word()
                                               : cur_mem_base + hit_offset(), rand_word()));
            endcase
        end
    endtask

    // fill all of data memory so that no later load reads a word never written
    task automatic fill_memory();
        for (int i = 0; i < DATA_WORDS; i++)
            send_req(make_req(OP_PRELOAD, rand_reg(), rand_reg(), rand_reg(),
                              cur_mem_base + (32'(i) << 2), rand_word()));
    endtask

    // extremes, every operation but halt and the miss cases, from a known register state
    task automatic directed_checks();
        logic [31:0] mb;
        logic [31:0] top_word;
        mb = cur_mem_base;
        top_word = 32'(DATA_WORDS - 1) << 2;
        send_req(make_req(OP_ADDI, 5'd1, 5'd0, 5'd0, MAX_WORD, '0));
        send_req(make_req(OP_ADDI, 5'd2, 5'd1, 5'd0, 32'd1, '0));
        send_req(make_req(OP_SUB, 5'd3, 5'd0, 5'd2, '0, '0));
        send_req(make_req(OP_ADD, 5'd31, 5'd1, 5'd2, '0, '0));
        send_req(make_req(OP_SUBI, 5'd4, 5'd0, 5'd0, MIN_WORD, '0));
        send_req(make_req(OP_ADD, 5'd5, 5'd31, 5'd31, '0, '0));
        send_req(make_req(OP_STUR, 5'd31, 5'd0, 5'd0, mb + top_word, '0));
        send_req(make_req(OP_LDUR, 5'd6, 5'd0, 5'd0, mb + top_word, '0));
        send_req(make_req(OP_LDUR, 5'd7, 5'd0, 5'd0, mb, '0));
        // past the top, unaligned, below the base
        send_req(make_req(OP_LDUR, 5'd8, 5'd0, 5'd0, mb + (32'(DATA_WORDS) << 2), '0));
        send_req(make_req(OP_STUR, 5'd1, 5'd0, 5'd0, mb + 32'd2, '0));
        send_req(make_req(OP_LDUR, 5'd9, 5'd0, 5'd0, mb - 32'd4, '0));
        send_req(make_req(OP_PRELOAD, 5'd0, 5'd0, 5'd0, mb + 32'd4, MIN_WORD));
        send_req(make_req(OP_PRELOAD, 5'd0, 5'd0, 5'd0, mb + 32'd1, 32'd1));
        send_req(make_req(OP_LDUR, 5'd10, 5'd0, 5'd0, mb + 32'd4, '0));
        send_req(make_req(OP_B, 5'd0, 5'd0, 5'd0, MAX_WORD, '0));
        send_req(make_req(OP_B, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, '0));
        send_req(make_req(OP_BL, 5'd0, 5'd0, 5'd0, 32'd3, '0));
        send_req(make_req(OP_BL, 5'd0, 5'd0, 5'd0, MIN_WORD, '0));
        send_req(make_req(OP_BR, 5'd0, 5'd31, 5'd0, '0, '0));
        send_req(make_req(OP_CBZ, 5'd0, 5'd0, 5'd0, 32'd5, '0));
        send_req(make_req(OP_CBZ, 5'd0, 5'd1, 5'd0, 32'd5, '0));
        send_req(make_req(OP_SPARE_FIRST, rand_reg(), rand_reg(), rand_reg(), $urandom(),
                          $urandom()));
        send_req(make_req(OP_SPARE_LAST, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // the unit stops for good, so the run ends on either a halt or a stack overflow
    task automatic stop_sequence();
        logic [31:0] sp0;
        sp0 = safe_word();
        if ($urandom_range(0, 1) == 1)
        begin
            // stack pointer one above the limit, then halt
            configure($urandom(), cur_mem_base, sp0, sp0 - 32'd1);
            send_req(make_req(OP_ADD, rand_target(), rand_reg(), rand_reg(), '0, '0));
            send_req(make_req(OP_HALT, rand_reg(), rand_reg(), rand_reg(), rand_word(), '0));
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                configure($urandom(), cur_mem_base, MIN_WORD, MIN_WORD);
            else
                configure($urandom(), cur_mem_base, sp0, MAX_WORD);
            // preload skips the stack check, the halt behind it fails it
            send_req(make_req(OP_PRELOAD, rand_reg(), rand_reg(), rand_reg(),
                              cur_mem_base + hit_offset(), rand_word()));
            send_req(make_req(OP_HALT, rand_reg(), rand_reg(), rand_reg(), rand_word(), '0));
        end
        // everything after the stop, preload included, is refused
        send_req(make_req(OP_PRELOAD, rand_reg(), rand_reg(), rand_reg(),
                          cur_mem_base + hit_offset(), rand_word()));
        send_req(make_req(OP_ADDI, rand_target(), rand_reg(), rand_reg(), rand_word(), '0));
        send_req(make_req(OP_B, rand_reg(), rand_reg(), rand_reg(), rand_word(), '0));
    endtask

    // stimulus and verdict
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);

        fill_memory();

        configure(32'd0, 32'd0, MAX_WORD, MIN_WORD);
        idle_on = 1'b1;
        directed_checks();
        random_items(250);

        // back to back with a long result hold-off, so the input side backs up
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, safe_word(), MIN_WORD);
        idle_on = 1'b0;
        long_hold = LONG_HOLD;
        random_items(250);

        configure($urandom(), $urandom(), 32'd0, MIN_WORD);
        idle_on = 1'b1;
        random_items(300);

        // sender drains in the middle, then another hold-off
        configure($urandom(), $urandom() & ~32'd3, safe_word(), MIN_WORD);
        random_items(150);
        wait_idle();
        long_hold = LONG_HOLD;
        random_items(150);

        configure(PC_START_RST, MEM_BASE_RST, STACK_INIT_RST, MIN_WORD);
        random_items(250);

        stop_sequence();
        wait_idle();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/lsx_pkg.sv
rtl/lsx_front.sv
rtl/lsx_back.sv
rtl/legv8_subset_execute_unit.sv
test/legv8_subset_execute_unit_checker.sv
test/legv8_subset_execute_unit_tb.sv
